// ----- src/prtq_pkg.sv -----
package prtq_pkg;

    // Default number of queue entries.
    localparam int QUEUE_DEPTH_DEFAULT = 16;

    // Field widths fixed by the interface.
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 4;
    localparam int TAG_W     = 16;
    localparam int STAMP_W   = 32;
    localparam int RETRY_W   = 8;
    localparam int CNT_OUT_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [RETRY_W-1:0] MARK_EXPIRED    = 8'hFF;
    localparam logic [STAMP_W-1:0] TIMEOUT_RST     = 32'd5000;
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 8'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_SWEEP = 2'd2,
        CMD_RETRY = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT     = 1'b0,
        CFG_MAX_RETRIES = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
        logic [RETRY_W-1:0] retries;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_CHK,
        ST_SWEEP_RD,
        ST_SWEEP_CHK,
        ST_DRAIN_RD,
        ST_DRAIN_CHK,
        ST_RETRY_CHK,
        ST_SHOW_RD,
        ST_SHOW_CHK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ADDR_FRONT,
        ADDR_PUSH,
        ADDR_SWEEP,
        ADDR_RETRY
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_PUSH,
        WD_MARK,
        WD_RETRY
    } wd_sel_t;

    typedef struct packed {
        logic      latch;
        logic      ram_we;
        addr_sel_t addr_sel;
        wd_sel_t   wd_sel;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      front_inc;
        logic      idx_inc;
        logic      removed_inc;
        logic      set_acc;
        logic      capture_show;
        logic      load_out;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic index_ok;
        logic sweep_end;
        logic expired;
        logic front_marked;
        logic retry_ok;
        logic out_free;
    } status_t;

endpackage

// ----- src/packet_retry_timeout_queue.sv -----
// Retransmit queue with timeout. The block keeps a ring of up to QUEUE_DEPTH
// pending packets, each with a 16-bit tag, the 32-bit millisecond time at which
// it was stored or last retried, and a retry count. Each input beat carries one
// command (push, pop, expiry sweep or retry) and produces exactly one result
// beat with the accept flag, the number of entries found expired, the
// number of entries held afterwards, and the tag and retry count of the popped
// entry or of the front entry (zero when the queue is empty). A sweep marks
// every held entry whose wrapping age exceeds timeout_ms with retry count 255
// and then drops marked entries from the front only; marked entries further
// back stay until a later sweep finds them at the front. A retry is granted
// when the index names a held entry whose count is below max_retries.
// Commands are processed one at a time through a single-port entry memory with
// a registered read, which sets the timing. A pop reads the front entry and
// removes it; a push writes the new entry unless full and then reads the front;
// a retry reads the indexed entry, rewrites it if granted and then reads the
// front. A sweep reads and checks each held entry in turn, then reads the front
// again and again, dropping it while it is marked. After the result is loaded
// the block returns to idle and takes the next command beat, which it does even
// while the previous result still waits for m_ready; a second result that
// finds the output register occupied holds until m_ready. Configuration writes
// (index 0 timeout_ms, index 1 max_retries) take effect at the clock edge at
// which cfg_we is high and are meant to be issued while no command is in
// flight.
module packet_retry_timeout_queue #(
    parameter int QUEUE_DEPTH = prtq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Command beats.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [prtq_pkg::CMD_W-1:0]        s_command,
    input  logic [prtq_pkg::STAMP_W-1:0]      s_now_ms,
    input  logic [prtq_pkg::IDX_W-1:0]        s_entry_index,
    input  logic [prtq_pkg::TAG_W-1:0]        s_packet_tag,

    // Result beats.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic [prtq_pkg::CNT_OUT_W-1:0]    m_removed_count,
    output logic [prtq_pkg::CNT_OUT_W-1:0]    m_entry_count,
    output logic [prtq_pkg::TAG_W-1:0]        m_front_tag,
    output logic [prtq_pkg::RETRY_W-1:0]      m_front_retries,

    // Register writes.
    input  logic                              cfg_we,
    input  logic [prtq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prtq_pkg::CFG_W-1:0]        cfg_wdata
);

    // The controller sequences memory accesses; the datapath owns the ring
    // pointers, the entry memory, the configuration and the output register.
    prtq_pkg::ctrl_t   ctrl;
    prtq_pkg::status_t status;

    prtq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    prtq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .status          (status),
        .s_command       (s_command),
        .s_now_ms        (s_now_ms),
        .s_entry_index   (s_entry_index),
        .s_packet_tag    (s_packet_tag),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_removed_count (m_removed_count),
        .m_entry_count   (m_entry_count),
        .m_front_tag     (m_front_tag),
        .m_front_retries (m_front_retries)
    );

endmodule

// ----- src/prtq_ram.sv -----
module prtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/prtq_datapath.sv -----
module prtq_datapath #(
    parameter int QUEUE_DEPTH = prtq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  prtq_pkg::ctrl_t                   ctrl,
    output prtq_pkg::status_t                 status,
    input  logic [prtq_pkg::CMD_W-1:0]        s_command,
    input  logic [prtq_pkg::STAMP_W-1:0]      s_now_ms,
    input  logic [prtq_pkg::IDX_W-1:0]        s_entry_index,
    input  logic [prtq_pkg::TAG_W-1:0]        s_packet_tag,
    input  logic                              cfg_we,
    input  logic [prtq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prtq_pkg::CFG_W-1:0]        cfg_wdata,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic [prtq_pkg::CNT_OUT_W-1:0]    m_removed_count,
    output logic [prtq_pkg::CNT_OUT_W-1:0]    m_entry_count,
    output logic [prtq_pkg::TAG_W-1:0]        m_front_tag,
    output logic [prtq_pkg::RETRY_W-1:0]      m_front_retries
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int XW = (CW > prtq_pkg::IDX_W) ? CW : prtq_pkg::IDX_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

    // Command fields held for the whole operation.
    prtq_pkg::cmd_t                 cmd_reg;
    logic [prtq_pkg::STAMP_W-1:0]   now_reg;
    logic [prtq_pkg::IDX_W-1:0]     index_reg;
    logic [prtq_pkg::TAG_W-1:0]     tag_reg;

    logic [prtq_pkg::STAMP_W-1:0]   timeout_reg;
    logic [prtq_pkg::RETRY_W-1:0]   max_retries_reg;

    logic [PW-1:0] front_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] removed_reg;
    logic          acc_reg;
    logic [prtq_pkg::TAG_W-1:0]   show_tag_reg;
    logic [prtq_pkg::RETRY_W-1:0] show_ret_reg;

    logic                            m_valid_reg;
    logic                            out_acc_reg;
    logic [prtq_pkg::CNT_OUT_W-1:0]  out_removed_reg;
    logic [prtq_pkg::CNT_OUT_W-1:0]  out_count_reg;
    logic [prtq_pkg::TAG_W-1:0]      out_tag_reg;
    logic [prtq_pkg::RETRY_W-1:0]    out_ret_reg;

    prtq_pkg::entry_t rd_entry;
    prtq_pkg::entry_t wr_entry;
    logic [CW-1:0]    offset;
    logic [SW-1:0]    slot_sum;
    logic [SW-1:0]    slot_wrap;
    logic [PW-1:0]    slot;
    logic [XW-1:0]    index_x;
    logic [XW-1:0]    count_x;
    logic [prtq_pkg::STAMP_W-1:0] age;

    assign index_x = XW'(index_reg);
    assign count_x = XW'(count_reg);

    // Ring slot of the entry at a given offset from the front.
    always_comb begin
        unique case (ctrl.addr_sel)
            prtq_pkg::ADDR_FRONT: offset = '0;
            prtq_pkg::ADDR_PUSH:  offset = count_reg;
            prtq_pkg::ADDR_SWEEP: offset = idx_reg;
            prtq_pkg::ADDR_RETRY: offset = index_x[CW-1:0];
        endcase
        slot_sum  = SW'(front_reg) + SW'(offset);
        slot_wrap = (slot_sum >= DEPTH_S) ? (slot_sum - DEPTH_S) : slot_sum;
        slot      = slot_wrap[PW-1:0];
    end

    always_comb begin
        wr_entry = rd_entry;
        unique case (ctrl.wd_sel)
            prtq_pkg::WD_PUSH: begin
                wr_entry.tag     = tag_reg;
                wr_entry.stamp   = now_reg;
                wr_entry.retries = '0;
            end
            prtq_pkg::WD_MARK: begin
                wr_entry.retries = prtq_pkg::MARK_EXPIRED;
            end
            prtq_pkg::WD_RETRY: begin
                wr_entry.stamp   = now_reg;
                wr_entry.retries = rd_entry.retries + 1'b1;
            end
            default: begin
                wr_entry = rd_entry;
            end
        endcase
    end

    prtq_ram #(
        .WIDTH ($bits(prtq_pkg::entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ctrl.ram_we),
        .waddr (slot),
        .wdata (wr_entry),
        .raddr (slot),
        .rdata (rd_entry)
    );

    assign age = now_reg - rd_entry.stamp;

    always_comb begin
        status.cmd          = cmd_reg;
        status.empty        = (count_reg == '0);
        status.full         = (count_reg == DEPTH_C);
        status.index_ok     = (index_x < count_x);
        status.sweep_end    = (idx_reg == count_reg);
        status.expired      = (age > timeout_reg);
        status.front_marked = (rd_entry.retries == prtq_pkg::MARK_EXPIRED);
        status.retry_ok     = (rd_entry.retries < max_retries_reg);
        status.out_free     = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg     <= prtq_pkg::TIMEOUT_RST;
            max_retries_reg <= prtq_pkg::MAX_RETRIES_RST;
        end else if (cfg_we) begin
            if (cfg_index == prtq_pkg::CFG_TIMEOUT) begin
                timeout_reg <= cfg_wdata;
            end else begin
                max_retries_reg <= cfg_wdata[prtq_pkg::RETRY_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.latch) begin
            cmd_reg   <= prtq_pkg::cmd_t'(s_command);
            now_reg   <= s_now_ms;
            index_reg <= s_entry_index;
            tag_reg   <= s_packet_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg    <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            removed_reg  <= '0;
            acc_reg      <= 1'b0;
            show_tag_reg <= '0;
            show_ret_reg <= '0;
        end else begin
            if (ctrl.latch) begin
                idx_reg      <= '0;
                removed_reg  <= '0;
                acc_reg      <= 1'b0;
                show_tag_reg <= '0;
                show_ret_reg <= '0;
            end
            if (ctrl.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (ctrl.removed_inc) begin
                removed_reg <= removed_reg + 1'b1;
            end
            if (ctrl.set_acc) begin
                acc_reg <= 1'b1;
            end
            if (ctrl.capture_show) begin
                show_tag_reg <= rd_entry.tag;
                show_ret_reg <= rd_entry.retries;
            end
            if (ctrl.cnt_inc) begin
                count_reg <= count_reg + 1'b1;
            end else if (ctrl.cnt_dec) begin
                count_reg <= count_reg - 1'b1;
            end
            if (ctrl.front_inc) begin
                front_reg <= (front_reg == LAST_SLOT) ? '0 : (front_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            out_acc_reg     <= acc_reg;
            out_removed_reg <= prtq_pkg::CNT_OUT_W'(removed_reg);
            out_count_reg   <= prtq_pkg::CNT_OUT_W'(count_reg);
            out_tag_reg     <= show_tag_reg;
            out_ret_reg     <= show_ret_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = out_acc_reg;
    assign m_removed_count = out_removed_reg;
    assign m_entry_count   = out_count_reg;
    assign m_front_tag     = out_tag_reg;
    assign m_front_retries = out_ret_reg;

endmodule

// ----- src/prtq_ctrl.sv -----
module prtq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  prtq_pkg::status_t status,
    output prtq_pkg::ctrl_t   ctrl
);

    prtq_pkg::state_t state_reg;
    prtq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prtq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        ctrl          = '0;
        ctrl.addr_sel = prtq_pkg::ADDR_FRONT;
        ctrl.wd_sel   = prtq_pkg::WD_PUSH;
        s_ready       = 1'b0;

        unique case (state_reg)
            prtq_pkg::ST_IDLE: begin
                // No beat is taken while reset is held.
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    ctrl.latch = 1'b1;
                    state_next = prtq_pkg::ST_EXEC;
                end
            end
            prtq_pkg::ST_EXEC: begin
                unique case (status.cmd)
                    prtq_pkg::CMD_PUSH: begin
                        if (!status.full) begin
                            ctrl.addr_sel = prtq_pkg::ADDR_PUSH;
                            ctrl.wd_sel   = prtq_pkg::WD_PUSH;
                            ctrl.ram_we   = 1'b1;
                            ctrl.cnt_inc  = 1'b1;
                            ctrl.set_acc  = 1'b1;
                        end
                        state_next = prtq_pkg::ST_SHOW_RD;
                    end
                    prtq_pkg::CMD_POP: begin
                        state_next = status.empty ? prtq_pkg::ST_DONE
                                                  : prtq_pkg::ST_POP_CHK;
                    end
                    prtq_pkg::CMD_SWEEP: begin
                        ctrl.set_acc = 1'b1;
                        state_next   = prtq_pkg::ST_SWEEP_RD;
                    end
                    prtq_pkg::CMD_RETRY: begin
                        ctrl.addr_sel = prtq_pkg::ADDR_RETRY;
                        state_next = status.index_ok ? prtq_pkg::ST_RETRY_CHK
                                                     : prtq_pkg::ST_SHOW_RD;
                    end
                endcase
            end
            prtq_pkg::ST_POP_CHK: begin
                ctrl.capture_show = 1'b1;
                ctrl.set_acc      = 1'b1;
                ctrl.front_inc    = 1'b1;
                ctrl.cnt_dec      = 1'b1;
                state_next        = prtq_pkg::ST_DONE;
            end
            prtq_pkg::ST_SWEEP_RD: begin
                ctrl.addr_sel = prtq_pkg::ADDR_SWEEP;
                state_next = status.sweep_end ? prtq_pkg::ST_DRAIN_RD
                                              : prtq_pkg::ST_SWEEP_CHK;
            end
            prtq_pkg::ST_SWEEP_CHK: begin
                ctrl.addr_sel = prtq_pkg::ADDR_SWEEP;
                ctrl.wd_sel   = prtq_pkg::WD_MARK;
                if (status.expired) begin
                    ctrl.ram_we      = 1'b1;
                    ctrl.removed_inc = 1'b1;
                end
                ctrl.idx_inc = 1'b1;
                state_next   = prtq_pkg::ST_SWEEP_RD;
            end
            prtq_pkg::ST_DRAIN_RD: begin
                state_next = status.empty ? prtq_pkg::ST_DONE
                                          : prtq_pkg::ST_DRAIN_CHK;
            end
            prtq_pkg::ST_DRAIN_CHK: begin
                if (status.front_marked) begin
                    ctrl.front_inc = 1'b1;
                    ctrl.cnt_dec   = 1'b1;
                    state_next     = prtq_pkg::ST_DRAIN_RD;
                end else begin
                    ctrl.capture_show = 1'b1;
                    state_next        = prtq_pkg::ST_DONE;
                end
            end
            prtq_pkg::ST_RETRY_CHK: begin
                ctrl.addr_sel = prtq_pkg::ADDR_RETRY;
                ctrl.wd_sel   = prtq_pkg::WD_RETRY;
                if (status.retry_ok) begin
                    ctrl.ram_we  = 1'b1;
                    ctrl.set_acc = 1'b1;
                end
                state_next = prtq_pkg::ST_SHOW_RD;
            end
            prtq_pkg::ST_SHOW_RD: begin
                state_next = status.empty ? prtq_pkg::ST_DONE
                                          : prtq_pkg::ST_SHOW_CHK;
            end
            prtq_pkg::ST_SHOW_CHK: begin
                ctrl.capture_show = 1'b1;
                state_next        = prtq_pkg::ST_DONE;
            end
            prtq_pkg::ST_DONE: begin
                if (status.out_free) begin
                    ctrl.load_out = 1'b1;
                    state_next    = prtq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = prtq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
